@@ rtl/matrix_permutation_apply_defines.svh @@
// assertion macros for the matrix permutation block
// used by files that carry concurrent checks; expects clk_i and rst_ni in scope
`ifndef MATRIX_PERMUTATION_APPLY_DEFINES_SVH
`define MATRIX_PERMUTATION_APPLY_DEFINES_SVH
`ifndef SYNTH
// check sampled on the clock, off while reset is asserted
`define MPA_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");
// check sampled on the clock, live during reset too
`define MPA_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("%m: check failed");
`else
`define MPA_ASSERT(name, prop)
`define MPA_ASSERT_ALWAYS(name, prop)
`endif
`endif

@@ rtl/mpa_pkg.sv @@
`timescale 1ns / 1ps
// shared constants for the matrix permutation block
// no dependencies; used by the channel interfaces and the top level
package mpa_pkg;

  // field widths of the request and response words
  localparam int KindW  = 3;
  localparam int IdxW   = 6;
  localparam int WordW  = 64;
  localparam int RangeW = 7;

  // request kinds
  localparam logic [KindW-1:0] KindWrPerm = 3'd0;
  localparam logic [KindW-1:0] KindWrElem = 3'd1;
  localparam logic [KindW-1:0] KindApply  = 3'd2;
  localparam logic [KindW-1:0] KindRdElem = 3'd3;
  localparam logic [KindW-1:0] KindRdPerm = 3'd4;

  // response status codes
  localparam logic StatusOk      = 1'b0;
  localparam logic StatusBadPerm = 1'b1;

endpackage

@@ rtl/mpa_req_if.sv @@
`timescale 1ns / 1ps
// request channel: valid/ready handshake plus the request word fields
// depends on mpa_pkg for field widths
interface mpa_req_if;
  logic                        valid;
  logic                        ready;
  logic [mpa_pkg::KindW-1:0]   kind;
  logic [mpa_pkg::IdxW-1:0]    row;
  logic [mpa_pkg::IdxW-1:0]    col;
  logic [mpa_pkg::WordW-1:0]   value;
  logic [mpa_pkg::RangeW-1:0]  range_start;
  logic [mpa_pkg::RangeW-1:0]  range_end;
  logic [mpa_pkg::RangeW-1:0]  length;
  logic                        direction;

  modport source (
    output valid, kind, row, col, value, range_start, range_end, length, direction,
    input  ready
  );
  modport sink (
    input  valid, kind, row, col, value, range_start, range_end, length, direction,
    output ready
  );
endinterface

@@ rtl/mpa_rsp_if.sv @@
`timescale 1ns / 1ps
// response channel: valid/ready handshake plus the response word fields
// depends on mpa_pkg for field widths
interface mpa_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [mpa_pkg::WordW-1:0]  data;
  logic                       status;

  modport source (
    output valid, data, status,
    input  ready
  );
  modport sink (
    input  valid, data, status,
    output ready
  );
endinterface

@@ rtl/matrix_permutation_apply.sv @@
`timescale 1ns / 1ps
// Matrix permutation engine, top level.
// Holds a DIM x DIM matrix store and a DIM-entry permutation table.
// Depends on mpa_pkg, mpa_req_if, mpa_rsp_if, mpa_ram and the assertion header.
//
// Usage:
//   req_i carries one request word (write perm, write element, apply, read element,
//   read perm); rsp_o returns exactly one response word per request, in order.
//   One request is in flight at a time; req_i.ready is low while it runs.
//   Writes and unknown kinds finish in the accept cycle; reads finish after the
//   registered ram read. Apply walks the positions; per out-of-place position it does
//   the entry read, the search probes, the second table write and the swap loop, each
//   ram used through its single read port.
//   The response sits in an output register until taken; a new request is taken
//   in the same cycle the receiver takes the previous response.
//   Reset clears the sequencer and the output valid; the matrix and table contents
//   are undefined until written. There is no clearing pass.
//   A stalled receiver simply holds the response and keeps req_i.ready low.
module matrix_permutation_apply #(
  parameter int DIM = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  mpa_req_if.sink        req_i,
  mpa_rsp_if.source      rsp_o
);

`include "matrix_permutation_apply_defines.svh"

  // index widths: table entry, matrix address, counters able to hold DIM and 127
  localparam int AW  = $clog2(DIM);
  localparam int MAW = $clog2(DIM * DIM);
  localparam int CW  = ($clog2(DIM + 1) > mpa_pkg::RangeW) ? $clog2(DIM + 1)
                                                           : mpa_pkg::RangeW;
  localparam int WW  = mpa_pkg::WordW;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDEL  = 4'd1;
  localparam logic [3:0] S_RDPM  = 4'd2;
  localparam logic [3:0] S_AP_I  = 4'd3;
  localparam logic [3:0] S_AP_P  = 4'd4;
  localparam logic [3:0] S_AP_J  = 4'd5;
  localparam logic [3:0] S_AP_JC = 4'd6;
  localparam logic [3:0] S_AP_WI = 4'd7;
  localparam logic [3:0] S_SW_A  = 4'd8;
  localparam logic [3:0] S_SW_B  = 4'd9;
  localparam logic [3:0] S_SW_W1 = 4'd10;
  localparam logic [3:0] S_SW_W2 = 4'd11;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, k_q, k_d, end_q, end_d, len_q, len_d;
  logic [AW-1:0] p_q, p_d;
  logic          dir_q, dir_d;
  logic          rd_ok_q, rd_ok_d;
  logic [WW-1:0] a_word_q, a_word_d;

  logic          out_valid_q, out_valid_d;
  logic [WW-1:0] out_data_q;
  logic          out_status_q;

  logic          finish;
  logic [WW-1:0] fin_data;
  logic          fin_status;
  logic          accept;

  logic          perm_we;
  logic [AW-1:0] perm_waddr, perm_wdata, perm_raddr, perm_rdata;
  logic          mat_we;
  logic [MAW-1:0] mat_waddr, mat_raddr;
  logic [WW-1:0] mat_wdata, mat_rdata;

  logic [CW-1:0] row_w, col_w, p_ext, rng_end_w, len_w;
  logic          row_ok, col_ok;
  logic [MAW-1:0] addr_a, addr_b;

  // matrix element (r, c) lives at r + c * DIM
  function automatic logic [MAW-1:0] cell_addr(input logic [CW-1:0] r,
                                                input logic [CW-1:0] c);
    logic [MAW-1:0] dim_m;
    dim_m = MAW'(DIM);
    return MAW'(r) + MAW'(c) * dim_m;
  endfunction

  // storage
  mpa_ram #(.Width(AW), .Depth(DIM)) u_perm_ram (
    .clk_i   (clk_i),
    .we_i    (perm_we),
    .waddr_i (perm_waddr),
    .wdata_i (perm_wdata),
    .raddr_i (perm_raddr),
    .rdata_o (perm_rdata)
  );

  mpa_ram #(.Width(WW), .Depth(DIM * DIM)) u_mat_ram (
    .clk_i   (clk_i),
    .we_i    (mat_we),
    .waddr_i (mat_waddr),
    .wdata_i (mat_wdata),
    .raddr_i (mat_raddr),
    .rdata_o (mat_rdata)
  );

  // handshake
  assign req_i.ready  = (state_q == S_IDLE) && (!out_valid_q || rsp_o.ready);
  assign accept       = req_i.valid && req_i.ready;
  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.data   = out_data_q;
  assign rsp_o.status = out_status_q;

  // request field decode
  assign row_w     = CW'(req_i.row);
  assign col_w     = CW'(req_i.col);
  assign row_ok    = row_w < CW'(DIM);
  assign col_ok    = col_w < CW'(DIM);
  assign rng_end_w = CW'(req_i.range_end);
  assign len_w     = CW'(req_i.length);

  // swap pair addresses for the current column or row element
  assign p_ext  = CW'(p_q);
  assign addr_a = dir_q ? cell_addr(p_ext, k_q) : cell_addr(k_q, p_ext);
  assign addr_b = dir_q ? cell_addr(i_q, k_q)   : cell_addr(k_q, i_q);

  // sequencer
  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    end_d      = end_q;
    len_d      = len_q;
    p_d        = p_q;
    dir_d      = dir_q;
    rd_ok_d    = rd_ok_q;
    a_word_d   = a_word_q;
    finish     = 1'b0;
    fin_data   = '0;
    fin_status = mpa_pkg::StatusOk;
    perm_we    = 1'b0;
    perm_waddr = i_q[AW-1:0];
    perm_wdata = i_q[AW-1:0];
    perm_raddr = i_q[AW-1:0];
    mat_we     = 1'b0;
    mat_waddr  = addr_a;
    mat_wdata  = mat_rdata;
    mat_raddr  = addr_a;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_i.kind)
            mpa_pkg::KindWrPerm: begin
              perm_we    = row_ok;
              perm_waddr = row_w[AW-1:0];
              perm_wdata = req_i.value[AW-1:0];
              finish     = 1'b1;
            end
            mpa_pkg::KindWrElem: begin
              mat_we    = row_ok && col_ok;
              mat_waddr = cell_addr(row_w, col_w);
              mat_wdata = req_i.value;
              finish    = 1'b1;
            end
            mpa_pkg::KindApply: begin
              i_d     = CW'(req_i.range_start);
              end_d   = (rng_end_w > CW'(DIM)) ? CW'(DIM) : rng_end_w;
              len_d   = (len_w > CW'(DIM)) ? CW'(DIM) : len_w;
              dir_d   = req_i.direction;
              state_d = S_AP_I;
            end
            mpa_pkg::KindRdElem: begin
              mat_raddr = cell_addr(row_w, col_w);
              rd_ok_d   = row_ok && col_ok;
              state_d   = S_RDEL;
            end
            mpa_pkg::KindRdPerm: begin
              perm_raddr = row_w[AW-1:0];
              rd_ok_d    = row_ok;
              state_d    = S_RDPM;
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      // read responses
      S_RDEL: begin
        finish   = 1'b1;
        fin_data = rd_ok_q ? mat_rdata : '0;
        state_d  = S_IDLE;
      end
      S_RDPM: begin
        finish   = 1'b1;
        fin_data = rd_ok_q ? WW'(perm_rdata) : '0;
        state_d  = S_IDLE;
      end
      // next position of the walk
      S_AP_I: begin
        if (i_q < end_q) begin
          perm_raddr = i_q[AW-1:0];
          state_d    = S_AP_P;
        end else begin
          finish  = 1'b1;
          state_d = S_IDLE;
        end
      end
      // check the entry at position i
      S_AP_P: begin
        if (CW'(perm_rdata) >= CW'(DIM)) begin
          finish     = 1'b1;
          fin_status = mpa_pkg::StatusBadPerm;
          state_d    = S_IDLE;
        end else if (CW'(perm_rdata) == i_q) begin
          i_d     = i_q + 1'b1;
          state_d = S_AP_I;
        end else begin
          p_d     = perm_rdata;
          j_d     = i_q + 1'b1;
          state_d = S_AP_J;
        end
      end
      // search probe: issue read of entry j
      S_AP_J: begin
        if (j_q >= CW'(DIM)) begin
          finish     = 1'b1;
          fin_status = mpa_pkg::StatusBadPerm;
          state_d    = S_IDLE;
        end else begin
          perm_raddr = j_q[AW-1:0];
          state_d    = S_AP_JC;
        end
      end
      // search probe: compare entry j with i
      S_AP_JC: begin
        if (CW'(perm_rdata) == i_q) begin
          perm_we    = 1'b1;
          perm_waddr = j_q[AW-1:0];
          perm_wdata = p_q;
          state_d    = S_AP_WI;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_AP_J;
        end
      end
      // position i now maps to itself
      S_AP_WI: begin
        perm_we    = 1'b1;
        perm_waddr = i_q[AW-1:0];
        perm_wdata = i_q[AW-1:0];
        k_d        = '0;
        state_d    = S_SW_A;
      end
      // swap loop: read a, read b, write a, write b
      S_SW_A: begin
        if (k_q < len_q) begin
          mat_raddr = addr_a;
          state_d   = S_SW_B;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_AP_I;
        end
      end
      S_SW_B: begin
        a_word_d  = mat_rdata;
        mat_raddr = addr_b;
        state_d   = S_SW_W1;
      end
      S_SW_W1: begin
        mat_we    = 1'b1;
        mat_waddr = addr_a;
        mat_wdata = mat_rdata;
        state_d   = S_SW_W2;
      end
      S_SW_W2: begin
        mat_we    = 1'b1;
        mat_waddr = addr_b;
        mat_wdata = a_word_q;
        k_d       = k_q + 1'b1;
        state_d   = S_SW_A;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q && !rsp_o.ready;
    if (finish) begin
      out_valid_d = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    i_q      <= i_d;
    j_q      <= j_d;
    k_q      <= k_d;
    end_q    <= end_d;
    len_q    <= len_d;
    p_q      <= p_d;
    dir_q    <= dir_d;
    rd_ok_q  <= rd_ok_d;
    a_word_q <= a_word_d;
    if (finish) begin
      out_data_q   <= fin_data;
      out_status_q <= fin_status;
    end
  end

  // checks
  `MPA_ASSERT(a_no_overrun, finish |-> (!out_valid_q || rsp_o.ready))
  `MPA_ASSERT(a_accept_progress, accept |=> (state_q != S_IDLE) || out_valid_q)
  `MPA_ASSERT(a_probe_in_table, (state_q == S_AP_JC) |-> (j_q < CW'(DIM)))
  `MPA_ASSERT(a_bad_has_no_data, (rsp_o.valid && rsp_o.status) |-> (rsp_o.data == '0))
  `MPA_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> (state_q == S_IDLE) || rst_ni)

endmodule

@@ rtl/mpa_ram.sv @@
`timescale 1ns / 1ps
// simple dual-port ram: one write port, one read port with registered data
// no dependencies; instanced for the matrix store and the permutation table
module mpa_ram #(
  parameter int Width = 64,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data registered and ready in the cycle after the address
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
